/* hdl/aabb_frustum_classifier_top_defines.svh */
// Assertion macros shared by the box culling classifier RTL.
`ifndef AABB_FRUSTUM_CLASSIFIER_TOP_DEFINES_SVH
`define AABB_FRUSTUM_CLASSIFIER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define AFC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AFC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define AFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/afc_pkg.sv */
// Types and constants of the box culling classifier.
package afc_pkg;

   localparam int PLANE_COUNT      = 6;
   localparam int COORD_WIDTH      = 20;
   localparam int NORMAL_FRAC_BITS = 12;

   localparam int CFG_PLANES  = 6;
   localparam int MAX_PLANES  = 8;
   localparam int PLANE_IDX_W = $clog2(MAX_PLANES);
   localparam int CSR_W       = 64;
   localparam int NRM_W       = 14;
   localparam int DST_W       = 22;
   localparam int DST_LSB     = 3 * NRM_W;
   localparam int AXES        = 3;

   localparam int SUM_W  = COORD_WIDTH + 1;
   localparam int PROD_W = NRM_W + 1 + SUM_W;
   localparam int D_W    = DST_W + NORMAL_FRAC_BITS + 1;
   localparam int ACC_W  = ((PROD_W > D_W) ? PROD_W : D_W) + 3;

   localparam int LATENCY_CYCLES = 2 * PLANE_COUNT + 2;

   typedef enum logic [1:0] {
      CONT_OUTSIDE    = 2'd0,
      CONT_INTERSECTS = 2'd1,
      CONT_CONTAINS   = 2'd2
   } containment_type;

   typedef struct packed {
      logic                           valid;
      logic                           outside;
      logic                           all_in;
      logic [AXES-1:0][SUM_W-1:0]     sum;
      logic [AXES-1:0][SUM_W-1:0]     diff;
   } afc_flow_type;

   typedef struct packed {
      logic                   wr;
      logic [PLANE_IDX_W-1:0] index;
      logic [CSR_W-1:0]       data;
   } afc_csr_type;

endpackage

/* hdl/afc_cell.sv */
// One plane cell: holds a plane and tests the passing box against it in two stages.
`include "aabb_frustum_classifier_top_defines.svh"
module afc_cell import afc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [PLANE_IDX_W-1:0] cell_index,
   input  afc_csr_type            csr_req,
   input  afc_flow_type           flow_i,
   output afc_flow_type           flow_o
);

   logic [CSR_W-1:0]         plane_ff, plane_in;
   logic                     plane_we;

   afc_flow_type             a_flow_ff, a_flow_in;
   logic signed [PROD_W-1:0] prod_s_ff [AXES];
   logic signed [PROD_W-1:0] prod_s_in [AXES];
   logic signed [PROD_W-1:0] prod_r_ff [AXES];
   logic signed [PROD_W-1:0] prod_r_in [AXES];
   logic signed [NRM_W:0]    nrm_ext [AXES];
   logic signed [NRM_W:0]    nrm_abs [AXES];

   afc_flow_type             flow_o_ff, flow_o_in;
   logic signed [DST_W-1:0]  plane_dist;
   logic signed [ACC_W-1:0]  dterm, s_acc, r_acc, s_plus, s_minus;

   assign plane_we = csr_req.wr && (csr_req.index == cell_index) &&
                     (cell_index < PLANE_IDX_W'(CFG_PLANES));
   assign plane_in = plane_we ? csr_req.data : plane_ff;

   always_comb begin
      a_flow_in = flow_i;
      for (int a = 0; a < AXES; a++) begin
         nrm_ext[a]   = {plane_ff[a*NRM_W+NRM_W-1], plane_ff[a*NRM_W +: NRM_W]};
         nrm_abs[a]   = nrm_ext[a][NRM_W] ? -nrm_ext[a] : nrm_ext[a];
         prod_s_in[a] = PROD_W'(nrm_ext[a]) * PROD_W'($signed(flow_i.sum[a]));
         prod_r_in[a] = PROD_W'(nrm_abs[a]) * PROD_W'($signed(flow_i.diff[a]));
      end
   end

   always_comb begin
      plane_dist = $signed(plane_ff[DST_LSB +: DST_W]);
      dterm      = ACC_W'(plane_dist) <<< (NORMAL_FRAC_BITS + 1);
      s_acc      = dterm + ACC_W'(prod_s_ff[0]) + ACC_W'(prod_s_ff[1]) +
                   ACC_W'(prod_s_ff[2]);
      r_acc      = ACC_W'(prod_r_ff[0]) + ACC_W'(prod_r_ff[1]) + ACC_W'(prod_r_ff[2]);
      s_plus     = s_acc + r_acc;
      s_minus    = s_acc - r_acc;
      flow_o_in         = a_flow_ff;
      flow_o_in.outside = a_flow_ff.outside | s_plus[ACC_W-1];
      flow_o_in.all_in  = a_flow_ff.all_in & ~s_minus[ACC_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff  <= '0;
         a_flow_ff <= '0;
         flow_o_ff <= '0;
      end else begin
         plane_ff  <= plane_in;
         a_flow_ff <= a_flow_in;
         flow_o_ff <= flow_o_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < AXES; a++) begin
         prod_s_ff[a] <= prod_s_in[a];
         prod_r_ff[a] <= prod_r_in[a];
      end
   end

   assign flow_o = flow_o_ff;

   `AFC_ASSERT_NEXT(a_outside_sticks, clock, reset,
      a_flow_ff.valid && a_flow_ff.outside, flow_o_ff.valid && flow_o_ff.outside,
      "outside flag dropped in cell")
   `AFC_ASSERT_NEXT(a_partial_sticks, clock, reset,
      a_flow_ff.valid && !a_flow_ff.all_in, flow_o_ff.valid && !flow_o_ff.all_in,
      "partial flag dropped in cell")
   `AFC_ASSERT_NEXT(a_valid_advances, clock, reset,
      a_flow_ff.valid, flow_o_ff.valid,
      "request dropped in cell")

endmodule

/* hdl/aabb_frustum_classifier_top.sv */
// Top level of the box culling classifier: input stage, plane cell chain, result register.
//
// Usage:
//   Request channel: drive the six box corner ports and raise start; the request
//   is taken at a rising edge where start is high and busy is low. busy is high
//   during reset and in the first cycle after it, so one request is taken every cycle.
//   Result channel: rsp_strobe marks rsp_containment and rsp_visible for one
//   cycle, in request order. Results cannot be held off.
//   Pipeline: one input stage that forms corner sums and extents, two stages
//   per plane cell (products, then sums and sign tests), one result register.
//   Throughput: one box per cycle, set by the plane cell chain, where every
//   cell works on a different box.
//   Configuration: write a plane with csr_valid, csr_index and csr_data while
//   the chain is empty; csr_ready is always high. Indices past the last plane
//   register are dropped.
//   Reset: synchronous; clears all planes to zero and empties the chain, so
//   requests in flight are lost.
`include "aabb_frustum_classifier_top_defines.svh"
module aabb_frustum_classifier_top import afc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_z,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [PLANE_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]              csr_data,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_containment,
   output logic                          rsp_visible
);

   logic            busy_ff;
   afc_flow_type    prep_ff, prep_in;
   afc_csr_type     csr_req;
   afc_flow_type    flow_chain [PLANE_COUNT+1];
   afc_flow_type    last_flow;

   logic            rsp_strobe_ff, rsp_strobe_in;
   containment_type rsp_cont_ff, rsp_cont_in;
   logic            rsp_visible_ff, rsp_visible_in;

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      csr_req.wr    = csr_valid & csr_ready;
      csr_req.index = csr_index;
      csr_req.data  = csr_data;
   end

   always_comb begin
      prep_in.valid   = start & ~busy_ff;
      prep_in.outside = 1'b0;
      prep_in.all_in  = 1'b1;
      prep_in.sum[0]  = SUM_W'(req_box_min_x) + SUM_W'(req_box_max_x);
      prep_in.sum[1]  = SUM_W'(req_box_min_y) + SUM_W'(req_box_max_y);
      prep_in.sum[2]  = SUM_W'(req_box_min_z) + SUM_W'(req_box_max_z);
      prep_in.diff[0] = SUM_W'(req_box_max_x) - SUM_W'(req_box_min_x);
      prep_in.diff[1] = SUM_W'(req_box_max_y) - SUM_W'(req_box_min_y);
      prep_in.diff[2] = SUM_W'(req_box_max_z) - SUM_W'(req_box_min_z);
   end

   assign flow_chain[0] = prep_ff;

   for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
      afc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (PLANE_IDX_W'(k)),
         .csr_req    (csr_req),
         .flow_i     (flow_chain[k]),
         .flow_o     (flow_chain[k+1])
      );
   end

   assign last_flow = flow_chain[PLANE_COUNT];

   always_comb begin
      rsp_strobe_in = last_flow.valid;
      if (last_flow.outside) begin
         rsp_cont_in = CONT_OUTSIDE;
      end else if (last_flow.all_in) begin
         rsp_cont_in = CONT_CONTAINS;
      end else begin
         rsp_cont_in = CONT_INTERSECTS;
      end
      rsp_visible_in = ~last_flow.outside;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         prep_ff        <= '0;
         rsp_strobe_ff  <= 1'b0;
         rsp_cont_ff    <= CONT_OUTSIDE;
         rsp_visible_ff <= 1'b0;
      end else begin
         busy_ff        <= 1'b0;
         prep_ff        <= prep_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_cont_ff    <= rsp_cont_in;
         rsp_visible_ff <= rsp_visible_in;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_containment = rsp_cont_ff;
   assign rsp_visible     = rsp_visible_ff;

   `AFC_ASSERT_IMPLY(a_req_to_rsp, clock, reset, start && !busy, ##LATENCY_CYCLES rsp_strobe, "request produced no result")
   `AFC_ASSERT_IMPLY(a_rsp_from_req, clock, reset, rsp_strobe, $past(start && !busy, LATENCY_CYCLES), "result without request")
   `AFC_ASSERT_IMPLY(a_visible_match, clock, reset, rsp_strobe, rsp_visible == (rsp_containment != CONT_OUTSIDE), "visible flag disagrees with class")

endmodule

/* dv/aabb_frustum_classifier_top_tb.sv */
// Self-checking testbench for the six-plane box culling classifier: directed and random boxes.
`timescale 1ns / 100ps

module aabb_frustum_classifier_top_tb import afc_pkg::*; ();

   localparam int IDLE_LIMIT = 2000;
   localparam int CMIN       = -(1 << (COORD_WIDTH - 1));
   localparam int CMAX       = (1 << (COORD_WIDTH - 1)) - 1;

   typedef struct packed {
      logic [AXES-1:0][COORD_WIDTH-1:0] lo;
      logic [AXES-1:0][COORD_WIDTH-1:0] hi;
   } box_type;

   class cull_checker;
      logic [CSR_W-1:0] planes [MAX_PLANES];
      containment_type  expected_class_q [$];
      int               mismatch_count;

      function new();
         foreach (planes[i]) planes[i] = '0;
         mismatch_count = 0;
      endfunction

      function void set_plane(int idx, logic [CSR_W-1:0] val);
         if (idx < CFG_PLANES) planes[idx] = val;
      endfunction

      function int pending();
         return expected_class_q.size();
      endfunction

      function containment_type classify_box(box_type b);
         longint lo, hi, n, s, rad, d;
         logic [CSR_W-1:0] r;
         bit outside, all_in;
         outside = 1'b0;
         all_in  = 1'b1;
         for (int p = 0; p < PLANE_COUNT && p < MAX_PLANES; p++) begin
            r   = planes[p];
            d   = $signed(r[DST_LSB +: DST_W]);
            s   = d * (longint'(1) << (NORMAL_FRAC_BITS + 1));
            rad = 0;
            for (int a = 0; a < AXES; a++) begin
               n   = $signed(r[a*NRM_W +: NRM_W]);
               lo  = $signed(b.lo[a]);
               hi  = $signed(b.hi[a]);
               s   = s + n * (lo + hi);
               rad = rad + ((n < 0) ? -n : n) * (hi - lo);
            end
            if (s + rad < 0) begin
               outside = 1'b1;
               break;
            end
            if (s - rad < 0) all_in = 1'b0;
         end
         if (outside) return CONT_OUTSIDE;
         else if (all_in) return CONT_CONTAINS;
         else return CONT_INTERSECTS;
      endfunction

      function void note_request(box_type b);
         expected_class_q.push_back(classify_box(b));
      endfunction

      task report(string msg);
         $display("ERROR %0t: %s", $time, msg);
         mismatch_count++;
      endtask

      task check_result(logic [1:0] cont, logic vis);
         containment_type exp_class;
         if (expected_class_q.size() == 0) begin
            report($sformatf("result with no request pending (containment %0d)", cont));
         end else begin
            exp_class = expected_class_q.pop_front();
            if (cont !== exp_class)
               report($sformatf("containment %0d, expected %0d", cont, exp_class));
            if (vis !== (exp_class != CONT_OUTSIDE))
               report($sformatf("visible %0b, expected %0b", vis, exp_class != CONT_OUTSIDE));
         end
      endtask
   endclass

   logic                          clock;
   logic                          reset           = 1'b1;
   logic                          start           = 1'b0;
   logic                          busy;
   logic signed [COORD_WIDTH-1:0] req_box_min_x   = '0;
   logic signed [COORD_WIDTH-1:0] req_box_min_y   = '0;
   logic signed [COORD_WIDTH-1:0] req_box_min_z   = '0;
   logic signed [COORD_WIDTH-1:0] req_box_max_x   = '0;
   logic signed [COORD_WIDTH-1:0] req_box_max_y   = '0;
   logic signed [COORD_WIDTH-1:0] req_box_max_z   = '0;
   logic                          csr_valid       = 1'b0;
   logic                          csr_ready;
   logic [PLANE_IDX_W-1:0]        csr_index       = '0;
   logic [CSR_W-1:0]              csr_data        = '0;
   logic                          rsp_strobe;
   logic [1:0]                    rsp_containment;
   logic                          rsp_visible;

   cull_checker      sb;
   logic [CSR_W-1:0] plane_set [CFG_PLANES];
   bit               gaps_on     = 1'b1;
   int               idle_cycles = 0;

   aabb_frustum_classifier_top uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_box_min_x   (req_box_min_x),
      .req_box_min_y   (req_box_min_y),
      .req_box_min_z   (req_box_min_z),
      .req_box_max_x   (req_box_max_x),
      .req_box_max_y   (req_box_max_y),
      .req_box_max_z   (req_box_max_z),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_containment (rsp_containment),
      .rsp_visible     (rsp_visible)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_containment, rsp_visible);
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic box_type mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
      box_type b;
      b.lo[0] = COORD_WIDTH'(x0);
      b.lo[1] = COORD_WIDTH'(y0);
      b.lo[2] = COORD_WIDTH'(z0);
      b.hi[0] = COORD_WIDTH'(x1);
      b.hi[1] = COORD_WIDTH'(y1);
      b.hi[2] = COORD_WIDTH'(z1);
      return b;
   endfunction

   function automatic logic [CSR_W-1:0] pack_plane(int nx, int ny, int nz, int d);
      return {DST_W'(d), NRM_W'(nz), NRM_W'(ny), NRM_W'(nx)};
   endfunction

   function automatic logic [CSR_W-1:0] tilted_plane(int p);
      int n [AXES];
      int dom;
      dom = $urandom_range(2048, 4096);
      for (int a = 0; a < AXES; a++) n[a] = int'($urandom_range(0, 2048)) - 1024;
      n[p / 2] = (p % 2) ? -dom : dom;
      return pack_plane(n[0], n[1], n[2], $urandom_range(50000, 350000));
   endfunction

   function automatic box_type random_box(int noise_pct);
      box_type         b;
      logic [4*32-1:0] raw;
      int              c, h;
      if (int'($urandom_range(0, 99)) < noise_pct) begin
         raw = {$urandom, $urandom, $urandom, $urandom};
         b   = raw[$bits(box_type)-1:0];
      end else begin
         for (int a = 0; a < AXES; a++) begin
            c = int'($urandom_range(0, 800000)) - 400000;
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120000)
                                            : $urandom_range(0, 30000);
            b.lo[a] = COORD_WIDTH'(c - h);
            b.hi[a] = COORD_WIDTH'(c + h);
         end
      end
      return b;
   endfunction

   task send_box(box_type b);
      if (gaps_on && $urandom_range(0, 99) < 4) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      start         <= 1'b1;
      req_box_min_x <= b.lo[0];
      req_box_min_y <= b.lo[1];
      req_box_min_z <= b.lo[2];
      req_box_max_x <= b.hi[0];
      req_box_max_y <= b.hi[1];
      req_box_max_z <= b.hi[2];
      do @(posedge clock); while (busy);
      sb.note_request(b);
   endtask

   // hold requests until every result is back
   task drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task csr_write(int idx, logic [CSR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= PLANE_IDX_W'(idx);
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_plane(idx, val);
   endtask

   task write_planes(bit touch_unused);
      drain();
      for (int i = 0; i < CFG_PLANES; i++) csr_write(i, plane_set[i]);
      if (touch_unused) begin
         for (int i = CFG_PLANES; i < (1 << PLANE_IDX_W); i++) csr_write(i, {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
   endtask

   task run_random(int count, int noise_pct, bit drain_midway);
      for (int i = 0; i < count; i++) begin
         if (drain_midway && i == count / 2) drain();
         send_box(random_box(noise_pct));
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // planes at reset value: zero normals, zero distance
      send_box(mk_box(0, 0, 0, 0, 0, 0));
      send_box(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
      send_box(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));

      // axis-aligned frustum
      for (int p = 0; p < CFG_PLANES; p++) begin
         plane_set[p] = pack_plane((p / 2 == 0) ? ((p % 2) ? -4096 : 4096) : 0,
                                   (p / 2 == 1) ? ((p % 2) ? -4096 : 4096) : 0,
                                   (p / 2 == 2) ? ((p % 2) ? -4096 : 4096) : 0,
                                   200000);
      end
      write_planes(1'b1);
      send_box(mk_box(-1000, -1000, -1000, 1000, 1000, 1000));
      send_box(mk_box(-260000, -1000, -1000, -240000, 1000, 1000));
      send_box(mk_box(-210000, -1000, -1000, -190000, 1000, 1000));
      send_box(mk_box(-190000, -1000, -1000, -210000, 1000, 1000));
      send_box(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
      send_box(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
      send_box(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
      run_random(120, 15, 1'b1);

      // tilted frusta, one without idle gaps
      for (int k = 0; k < 3; k++) begin
         for (int p = 0; p < CFG_PLANES; p++) plane_set[p] = tilted_plane(p);
         write_planes(1'b0);
         gaps_on = (k != 1);
         run_random(100, 15, 1'b0);
      end
      gaps_on = 1'b1;

      // fully random plane words
      for (int k = 0; k < 2; k++) begin
         for (int p = 0; p < CFG_PLANES; p++) plane_set[p] = {$urandom, $urandom};
         write_planes(1'b1);
         run_random(40, 30, 1'b0);
      end

      // extreme plane words
      for (int k = 0; k < 3; k++) begin
         for (int p = 0; p < CFG_PLANES; p++) begin
            case (k)
               0: plane_set[p] = '1;
               1: plane_set[p] = pack_plane(8191, 8191, 8191, 2097151);
               default: plane_set[p] = pack_plane(-8192, -8192, -8192, -2097152);
            endcase
         end
         write_planes(1'b1);
         send_box(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
         send_box(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
         run_random(10, 30, 1'b0);
      end

      // zero normals: only the sign of the distance counts
      plane_set[0] = pack_plane(0, 0, 0, 0);
      plane_set[1] = pack_plane(0, 0, 0, 1);
      plane_set[2] = pack_plane(0, 0, 0, 2097151);
      plane_set[3] = pack_plane(0, 0, 0, 100);
      plane_set[4] = pack_plane(0, 0, 0, 7);
      plane_set[5] = pack_plane(0, 0, 0, 3);
      write_planes(1'b0);
      send_box(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
      run_random(10, 30, 1'b0);
      drain();
      csr_write(5, pack_plane(0, 0, 0, -1));
      csr_valid <= 1'b0;
      send_box(mk_box(0, 0, 0, 0, 0, 0));
      run_random(10, 30, 1'b0);

      drain();
      repeat (LATENCY_CYCLES + 4) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
